// ===== src/led_pkg.sv =====
// ----------------------------------------------------------------------------
// led_pkg
// shared types and constants of the local extrema detector
// ----------------------------------------------------------------------------
package led_pkg;

    // reported indices are always this wide, whatever the index counter width
    localparam int IDX_OUT_BITS = 16;

    typedef enum logic {
        KIND_MAX = 1'b0,
        KIND_MIN = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [IDX_OUT_BITS-1:0] run_first;
        logic [IDX_OUT_BITS-1:0] run_final;
    } t_report;

endpackage

// ===== src/local_extrema_detector.sv =====
// a report is registered into the result register (or the skid under stall) from the beat that closes its run
// throughput: one sample beat per cycle while o_stall is low; the run state is registered on each accepted beat
// a two-entry result stage (register plus skid) holds reports under output stall
// o_stall rises only while both result entries are occupied
// reset: synchronous, active low; clears run state, index and result stage
// ----------------------------------------------------------------------------
// local_extrema_detector
// streaming detector of local maxima and minima over runs of equal samples
// ----------------------------------------------------------------------------
module local_extrema_detector #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic                                   i_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_kind,
    output logic [led_pkg::IDX_OUT_BITS-1:0]       o_run_first,
    output logic [led_pkg::IDX_OUT_BITS-1:0]       o_run_final
);
    import led_pkg::*;

    logic    in_accept;
    logic    rep_valid;
    t_report rep;
    t_report out_rep;
    logic    full;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = full;

    led_run_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_rep_valid (rep_valid),
        .o_rep       (rep)
    );

    led_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rep_valid (rep_valid),
        .i_rep       (rep),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_rep       (out_rep),
        .o_full      (full)
    );

    assign o_kind      = out_rep.kind;
    assign o_run_first = out_rep.run_first;
    assign o_run_final = out_rep.run_final;

endmodule

// ===== src/led_run_tracker.sv =====
// ----------------------------------------------------------------------------
// led_run_tracker
// run state of the sample stream and the extremum decision for a closed run
// ----------------------------------------------------------------------------
module led_run_tracker #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    output logic                          o_rep_valid,
    output led_pkg::t_report              o_rep
);
    import led_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SAMPLES - 1);

    logic signed [SAMPLE_BITS-1:0] r_run_value, n_run_value;
    logic signed [SAMPLE_BITS-1:0] r_left_value, n_left_value;
    logic [IDX_W-1:0]              r_run_begin, n_run_begin;
    logic [IDX_W-1:0]              r_run_end, n_run_end;
    logic [IDX_W-1:0]              r_next_index, n_next_index;
    logic                          r_left_valid, n_left_valid;
    logic                          r_have_run, n_have_run;

    logic                          closes_run;
    logic                          is_max;
    logic                          is_min;
    logic [IDX_OUT_BITS-1:0]       first_idx;
    logic [IDX_OUT_BITS-1:0]       final_idx;

    // a run closes when a differing beat arrives behind an open run
    assign closes_run = i_accept && r_have_run && (i_sample != r_run_value);
    assign is_max     = r_left_valid && (r_left_value < r_run_value) &&
                        (i_sample < r_run_value);
    assign is_min     = r_left_valid && (r_left_value > r_run_value) &&
                        (i_sample > r_run_value);

    generate
        if (IDX_W >= IDX_OUT_BITS) begin : g_idx_trunc
            assign first_idx = r_run_begin[IDX_OUT_BITS-1:0];
            assign final_idx = r_run_end[IDX_OUT_BITS-1:0];
        end else begin : g_idx_ext
            assign first_idx = {{(IDX_OUT_BITS-IDX_W){1'b0}}, r_run_begin};
            assign final_idx = {{(IDX_OUT_BITS-IDX_W){1'b0}}, r_run_end};
        end
    endgenerate

    assign o_rep_valid     = closes_run && (is_max || is_min);
    assign o_rep.kind      = is_max ? KIND_MAX : KIND_MIN;
    assign o_rep.run_first = first_idx;
    assign o_rep.run_final = final_idx;

    always_comb begin
        n_run_value  = r_run_value;
        n_left_value = r_left_value;
        n_run_begin  = r_run_begin;
        n_run_end    = r_run_end;
        n_next_index = r_next_index;
        n_left_valid = r_left_valid;
        n_have_run   = r_have_run;
        if (i_accept) begin
            if (!r_have_run) begin
                n_run_value = i_sample;
                n_run_begin = r_next_index;
                n_have_run  = 1'b1;
            end else if (closes_run) begin
                n_left_value = r_run_value;
                n_left_valid = 1'b1;
                n_run_value  = i_sample;
                n_run_begin  = r_next_index;
            end
            n_run_end = r_next_index;
            // index saturates at the top of the range
            if (r_next_index < LAST_IDX) begin
                n_next_index = r_next_index + 1'b1;
            end
            if (i_last) begin
                n_run_value  = '0;
                n_left_value = '0;
                n_run_begin  = '0;
                n_run_end    = '0;
                n_next_index = '0;
                n_left_valid = 1'b0;
                n_have_run   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value  <= '0;
            r_left_value <= '0;
            r_run_begin  <= '0;
            r_run_end    <= '0;
            r_next_index <= '0;
            r_left_valid <= 1'b0;
            r_have_run   <= 1'b0;
        end else begin
            r_run_value  <= n_run_value;
            r_left_value <= n_left_value;
            r_run_begin  <= n_run_begin;
            r_run_end    <= n_run_end;
            r_next_index <= n_next_index;
            r_left_valid <= n_left_valid;
            r_have_run   <= n_have_run;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> !r_have_run && !r_left_valid && (r_next_index == '0))
        else $error("last beat did not clear the run state");

    a_left_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_valid |-> r_have_run)
        else $error("left neighbour held without an open run");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_index <= LAST_IDX) && (r_run_begin <= r_run_end || !r_have_run))
        else $error("run indices out of order or beyond the bound");

endmodule

// ===== src/led_out_stage.sv =====
// ----------------------------------------------------------------------------
// led_out_stage
// result register with a skid entry, so the input never waits on a stalled
// result beat unless a second one is already parked
// ----------------------------------------------------------------------------
module led_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rep_valid,
    input  led_pkg::t_report i_rep,
    input  logic             i_stall,
    output logic             o_valid,
    output led_pkg::t_report o_rep,
    output logic             o_full
);
    import led_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_report r_out, n_out;
    t_report r_skid, n_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // upstream is held off while the skid entry is occupied
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            n_out_valid = i_rep_valid;
            n_out       = i_rep;
        end else if (i_rep_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_rep   = r_out;
    assign o_full  = r_skid_valid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with an empty result register");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_stall |=> r_skid_valid && $stable(r_skid))
        else $error("parked result beat lost while stalled");

    a_skid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid && (r_out == $past(r_skid)))
        else $error("parked result beat not moved to the output");

endmodule
